### hw/rtl/stbs_pkg.sv
// Shared constants, codes and control structs for the sorted-table search core.
package stbs_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 1024;
   localparam int POS_W               = 10;
   localparam int VAL_W               = 32;
   localparam int REQ_DATA_W          = 96;
   localparam int RSP_DATA_W          = 16;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic write;   // store entry from request
      logic load;    // start a search
      logic step;    // evaluate current probe
      logic emit;    // copy result to output register
   } stbs_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic empty;   // requested range is empty after saturation
      logic finish;  // current probe ends the search
   } stbs_status_type;

endpackage

### hw/rtl/stbs_ctrl.sv
// Control state machine: handshakes and search sequencing.
module stbs_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic                     req_op,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output stbs_pkg::stbs_cmd_type    cmd,
   input  stbs_pkg::stbs_status_type status
);
   import stbs_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CMP  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_op == OP_SEARCH) begin
                  cmd.load = 1'b1;
                  state_in = status.empty ? ST_DONE : ST_CMP;
               end else begin
                  cmd.write = 1'b1;
               end
            end
         end
         ST_CMP: begin
            cmd.step = 1'b1;
            if (status.finish) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### hw/rtl/stbs_datapath.sv
// Table memory, search bounds, probe compare and result registers.
module stbs_datapath #(
   parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic [stbs_pkg::POS_W-1:0]    req_entry_index,
   input  logic signed [stbs_pkg::VAL_W-1:0] req_entry_value,
   input  logic [stbs_pkg::POS_W-1:0]    req_range_start,
   input  logic [stbs_pkg::POS_W-1:0]    req_range_end,
   input  logic signed [stbs_pkg::VAL_W-1:0] req_search_key,
   input  stbs_pkg::stbs_cmd_type         cmd,
   output stbs_pkg::stbs_status_type      status,
   output logic                          rsp_found,
   output logic [stbs_pkg::POS_W-1:0]    rsp_position
);
   import stbs_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int MW = (AW > POS_W) ? AW : POS_W;
   localparam logic [MW:0] DEPTH_W   = (MW+1)'(TABLE_DEPTH);
   localparam logic [MW:0] LAST_IDX  = (MW+1)'(TABLE_DEPTH - 1);

   logic signed [VAL_W-1:0] mem [TABLE_DEPTH];
   logic signed [VAL_W-1:0] rd_data_ff;

   logic [POS_W-1:0]        lo_ff, lo_in;
   logic [POS_W-1:0]        hi_ff, hi_in;
   logic [POS_W-1:0]        mid_ff, mid_in;
   logic signed [VAL_W-1:0] key_ff, key_in;
   logic                    found_ff, found_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic                    out_found_ff;
   logic [POS_W-1:0]        out_pos_ff;

   logic [POS_W-1:0]        hi_sat;
   logic [POS_W:0]          mid_sum;
   logic [AW-1:0]           rd_addr;
   logic [AW-1:0]           wr_addr;
   logic                    wr_ok;
   logic                    eq, lt;
   logic [MW-1:0]           rd_wide, wr_wide;

   // range end clamps to last table slot
   always_comb begin
      if ((MW+1)'(req_range_end) > LAST_IDX) begin
         hi_sat = POS_W'(LAST_IDX);
      end else begin
         hi_sat = req_range_end;
      end
   end

   assign status.empty = req_range_start > hi_sat;

   assign eq = (rd_data_ff == key_ff);
   assign lt = (rd_data_ff < key_ff);

   // halves that become empty end the search without another probe
   assign status.finish = eq || (lt && (mid_ff == hi_ff)) || (!lt && !eq && (mid_ff == lo_ff));

   always_comb begin
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      key_in   = key_ff;
      found_in = found_ff;
      pos_in   = pos_ff;
      if (cmd.load) begin
         lo_in    = req_range_start;
         hi_in    = hi_sat;
         key_in   = req_search_key;
         found_in = 1'b0;
         pos_in   = '0;
      end else if (cmd.step) begin
         if (eq) begin
            found_in = 1'b1;
            pos_in   = mid_ff;
         end else if (lt) begin
            lo_in = mid_ff + POS_W'(1);
         end else begin
            hi_in = mid_ff - POS_W'(1);
         end
      end
   end

   // next probe address straight from the updated bounds
   assign mid_sum = (POS_W+1)'(lo_in) + (POS_W+1)'(hi_in);
   assign mid_in  = mid_sum[POS_W:1];
   assign rd_wide = MW'(mid_in);
   assign rd_addr = rd_wide[AW-1:0];

   assign wr_wide = MW'(req_entry_index);
   assign wr_addr = wr_wide[AW-1:0];
   assign wr_ok   = (MW+1)'(req_entry_index) < DEPTH_W;

   always_ff @(posedge clock) begin
      if (cmd.write && wr_ok) begin
         mem[wr_addr] <= req_entry_value;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      key_ff   <= key_in;
      found_ff <= found_in;
      pos_ff   <= pos_in;
      if (cmd.emit) begin
         out_found_ff <= found_ff;
         out_pos_ff   <= pos_ff;
      end
   end

   assign rsp_found    = out_found_ff;
   assign rsp_position = out_pos_ff;

endmodule

### hw/rtl/sorted_table_binary_search_core.sv
// Top level of the sorted-table binary search core.
//
// The request channel (req_*) carries two kinds of request, selected by
// req_tuser: a write stores entry_value at entry_index; a search looks for
// search_key over the inclusive range [range_start, range_end] of a table
// that is assumed sorted ascending. Writes beyond the table are dropped and
// range_end clamps to the last slot. Each search returns one response
// (rsp_*): rsp_tuser is the found flag, rsp_tdata the matching index (zero
// when not found). Writes return none.
//
// A write leaves the core idle. A search with P probes, at most 11 for a
// 1024-entry range and none for an empty one, goes from acceptance to the
// done state, which loads the response register once the output register
// is free; only then is the next request taken. In each probe, the
// registered table read feeds the compare, which picks the bounds and the
// next read address. One request is in flight at a time. While the
// receiver stalls, the core still accepts writes and a new search, and
// holds that search's result until the output register is free.
// Reset clears the controller and the response valid; table contents are
// not cleared, so searches must only probe entries written since reset.
module sorted_table_binary_search_core #(
   parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // entry_index[9:0], entry_value[41:10], range_start[51:42],
   // range_end[61:52], search_key[93:62], zero pad[95:94]
   input  logic [stbs_pkg::REQ_DATA_W-1:0]   req_tdata,
   // op[0]
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // position[9:0], zero pad[15:10]
   output logic [stbs_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // found[0]
   output logic                              rsp_tuser
);
   import stbs_pkg::*;

   stbs_cmd_type            cmd;
   stbs_status_type         status;
   logic [POS_W-1:0]        entry_index;
   logic signed [VAL_W-1:0] entry_value;
   logic [POS_W-1:0]        range_start;
   logic [POS_W-1:0]        range_end;
   logic signed [VAL_W-1:0] search_key;
   logic                    found;
   logic [POS_W-1:0]        position;

   // request field unpacking
   assign entry_index = req_tdata[9:0];
   assign entry_value = req_tdata[41:10];
   assign range_start = req_tdata[51:42];
   assign range_end   = req_tdata[61:52];
   assign search_key  = req_tdata[93:62];

   stbs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   stbs_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .req_entry_index (entry_index),
      .req_entry_value (entry_value),
      .req_range_start (range_start),
      .req_range_end   (range_end),
      .req_search_key  (search_key),
      .cmd             (cmd),
      .status          (status),
      .rsp_found       (found),
      .rsp_position    (position)
   );

   assign rsp_tdata = {(RSP_DATA_W - POS_W)'(0), position};
   assign rsp_tuser = found;

   // a write never leaves the idle state
   a_write_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == OP_WRITE) |=> req_tready)
      else $error("core left idle after a table write");

   // a miss always reports position zero
   a_miss_pos_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("not-found response with nonzero position");

   // reset leaves no response pending
   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // the datapath is only stepped while no request can be taken
   a_step_blocks_req: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> !req_tready && !cmd.load && !cmd.write)
      else $error("probe step overlapped a request");

endmodule

### verif/sorted_table_binary_search_core_test.sv
// Self-checking testbench for the sorted-table binary search core.
module sorted_table_binary_search_core_test;

   localparam int TABLE_DEPTH  = stbs_pkg::TABLE_DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int SETTLE_CYCLES = 40;
   localparam int RANDOM_COUNT = 500;
   localparam int CALM_FROM    = 380;     // no idling on either side from here on

   localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

   // req_tdata layout, lowest field last
   typedef struct packed {
      logic [1:0]         pad;
      logic signed [31:0] search_key;
      logic [9:0]         range_end;
      logic [9:0]         range_start;
      logic signed [31:0] entry_value;
      logic [9:0]         entry_index;
   } search_request_type;

   typedef struct packed {
      logic       found;
      logic [9:0] position;
   } search_result_type;

   // Keeps its own copy of the table and predicts each search's answer at the
   // moment the request is accepted.
   class search_scoreboard;
      logic signed [31:0] entries [TABLE_DEPTH];
      search_result_type  answers_q[$];
      int                 failures;

      function int pending();
         return answers_q.size();
      endfunction

      function void note_request(logic op, search_request_type req);
         int                 lo;
         int                 hi;
         int                 mid;
         logic signed [31:0] key;
         search_result_type  res;
         if (op == stbs_pkg::OP_WRITE) begin
            if (int'(req.entry_index) < TABLE_DEPTH)
               entries[req.entry_index] = req.entry_value;
            return;
         end
         lo  = int'(req.range_start);
         hi  = int'(req.range_end);
         if (hi > TABLE_DEPTH - 1)
            hi = TABLE_DEPTH - 1;
         key = req.search_key;
         res = '0;
         while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (entries[mid] == key) begin
               res.found    = 1'b1;
               res.position = mid[9:0];
               break;
            end
            if (entries[mid] < key)
               lo = mid + 1;
            else
               hi = mid - 1;
         end
         answers_q.push_back(res);
      endfunction

      function void check_response(logic found, logic [stbs_pkg::RSP_DATA_W-1:0] data);
         search_result_type want;
         if (answers_q.size() == 0) begin
            $error("response with no search outstanding: found %0b position %0d",
                   found, data[9:0]);
            failures++;
            return;
         end
         want = answers_q.pop_front();
         if (found !== want.found) begin
            $error("found: expected %0b, actual %0b", want.found, found);
            failures++;
         end
         if (data[9:0] !== want.position) begin
            $error("position: expected %0d, actual %0d", want.position, data[9:0]);
            failures++;
         end
         if (data[15:10] !== 6'b0) begin
            $error("rsp pad: expected 0, actual %0h", data[15:10]);
            failures++;
         end
      endfunction
   endclass

   logic                            clock;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [stbs_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                            req_tuser  = stbs_pkg::OP_WRITE;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [stbs_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tuser;

   search_scoreboard   sb = new;
   logic signed [31:0] shadow [TABLE_DEPTH];  // stimulus-side copy, used to aim keys
   bit                 calm = 1'b0;
   int                 cycle_count = 0;

   sorted_table_binary_search_core #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: a hung handshake or a lost response ends up here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Monitor. Both DUT and testbench only change signals through nonblocking
   // updates, so values read here are the ones present at the edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_request(req_tuser, search_request_type'(req_tdata));
         if (rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tuser, rsp_tdata);
      end
   end

   // Receiver back-pressure: random stall bursts, none once calm.
   always begin
      @(posedge clock);
      if (!reset && !calm && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // All fields but the pad random; callers overwrite the ones the operation uses, so the
   // ignored fields still toggle.
   function automatic search_request_type random_request();
      search_request_type r;
      r.pad         = 2'b00;
      r.search_key  = $urandom;
      r.range_end   = $urandom_range(0, 1023);
      r.range_start = $urandom_range(0, 1023);
      r.entry_value = $urandom;
      r.entry_index = $urandom_range(0, 1023);
      return r;
   endfunction

   // Holds the request until accepted. valid is left high; the next request
   // or an idle burst decides what it does next.
   task automatic send_request(logic op, search_request_type r);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= r;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic sender_idle();
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   task automatic send_write(int idx, logic signed [31:0] val);
      search_request_type r;
      r             = random_request();
      r.entry_index = idx[9:0];
      r.entry_value = val;
      send_request(stbs_pkg::OP_WRITE, r);
      shadow[idx] = val;
      sender_idle();
   endtask

   task automatic send_search(int first, int last, logic signed [31:0] key);
      search_request_type r;
      r             = random_request();
      r.range_start = first[9:0];
      r.range_end   = last[9:0];
      r.search_key  = key;
      send_request(stbs_pkg::OP_SEARCH, r);
      sender_idle();
   endtask

   // Sender holds off until every outstanding search has answered.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Pick a value between the neighbors of idx so the table stays sorted.
   function automatic logic signed [31:0] sorted_value(int idx);
      longint lo;
      longint hi;
      longint off;
      lo = (idx > 0) ? longint'(shadow[idx - 1]) : longint'(VAL_MIN);
      hi = (idx < TABLE_DEPTH - 1) ? longint'(shadow[idx + 1]) : longint'(VAL_MAX);
      if (hi <= lo)
         return lo[31:0];
      off = longint'($urandom) % (hi - lo + 1);
      return 32'(lo + off);
   endfunction

   initial begin : stimulus
      int                 fill_vals[$];
      int                 first;
      int                 last;
      int                 pick;
      logic signed [31:0] key;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: a small sorted run with both extremes and duplicates in
      // slots 0..7. Searches stay inside those slots until the full fill.
      send_write(0, VAL_MIN);
      send_write(1, -32'sd5);
      send_write(2, -32'sd5);
      send_write(3, 32'sd0);
      send_write(4, 32'sd7);
      send_write(5, 32'sd7);
      send_write(6, 32'sd7);
      send_write(7, VAL_MAX);
      send_search(0, 7, VAL_MIN);
      send_search(0, 7, VAL_MAX);
      send_search(0, 7, 32'sd7);      // several equal entries
      send_search(0, 7, -32'sd5);
      send_search(0, 7, 32'sd3);      // falls between entries
      send_search(7, 7, VAL_MAX);     // single-slot range
      send_search(0, 0, 32'sd1);
      send_search(5, 4, 32'sd7);      // empty range
      send_search(1023, 0, VAL_MIN);  // empty range, widest inversion
      send_write(2, 32'sd100);        // table no longer sorted
      send_search(0, 7, 32'sd100);
      send_search(2, 2, 32'sd100);
      wait_drained();

      // Full sorted fill: random spread with duplicates and both extremes.
      for (int i = 0; i < TABLE_DEPTH; i++)
         fill_vals.push_back(int'($urandom));
      fill_vals.sort();
      for (int i = 1; i < TABLE_DEPTH; i++)
         if ($urandom_range(0, 9) == 0)
            fill_vals[i] = fill_vals[i - 1];
      fill_vals[0]               = VAL_MIN;
      fill_vals[TABLE_DEPTH - 1] = VAL_MAX;
      for (int i = 0; i < TABLE_DEPTH; i++)
         send_write(i, fill_vals[i]);

      // Whole-table searches, including the top slot alone.
      send_search(0, 1023, VAL_MIN);
      send_search(0, 1023, VAL_MAX);
      send_search(0, 1023, shadow[517]);
      send_search(1023, 1023, VAL_MAX);
      send_search(0, 1023, shadow[300] + 32'sd1);
      wait_drained();

      // Random: mostly searches over a mostly sorted table, some rewrites
      // that keep the order, a few that break it.
      for (int n = 0; n < RANDOM_COUNT; n++) begin
         if (n == CALM_FROM)
            calm = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 18) begin
            first = $urandom_range(0, 1023);
            send_write(first, sorted_value(first));
         end else if (pick < 23) begin
            send_write($urandom_range(0, 1023), $urandom);
         end else begin
            case ($urandom_range(0, 9))
               0: begin
                  first = $urandom_range(1, 1023);
                  last  = $urandom_range(0, first - 1);
               end
               1: begin
                  first = 0;
                  last  = 1023;
               end
               2: begin
                  first = $urandom_range(0, 1023);
                  last  = (first + $urandom_range(0, 3) > 1023) ?
                          1023 : first + $urandom_range(0, 3);
               end
               default: begin
                  first = $urandom_range(0, 1023);
                  last  = $urandom_range(first, 1023);
               end
            endcase
            pick = $urandom_range(0, 9);
            if (pick < 6)
               key = shadow[(first <= last) ? $urandom_range(first, last) :
                            $urandom_range(0, 1023)];
            else if (pick < 8)
               key = shadow[$urandom_range(0, 1023)] +
                     (($urandom_range(0, 1) == 1) ? 32'sd1 : -32'sd1);
            else
               key = $urandom;
            send_search(first, last, key);
         end
         if (n == RANDOM_COUNT / 2)
            wait_drained();
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (sb.failures == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
